>>> rtl/core/olb_pkg.sv
// Package for the leaky-bucket overshoot meter.
// Holds field widths, operation codes and fixed constants; depends on nothing.
package olb_pkg;

   localparam int unsigned LEVEL_W   = 48;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned BYTES_W   = 24;
   localparam int unsigned RATE_W    = 32;
   localparam int unsigned FPS_W     = 8;
   localparam int unsigned PROD_W    = 64;
   localparam int unsigned DIVISOR_W = 10;
   localparam int unsigned DSTEP_W   = 7;
   localparam int unsigned MSTEP_W   = 6;

   // Operation codes carried by each request.
   typedef enum logic [1:0] {
      OP_FRAME    = 2'd0,
      OP_SET_RATE = 2'd1,
      OP_RESET    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   // Milliseconds per second, the divisor of the leak computation.
   localparam logic [DIVISOR_W-1:0] MS_PER_S = 10'd1000;

   // Step counts of the serial units.
   localparam logic [MSTEP_W-1:0] MUL_STEPS       = 6'd32;
   localparam logic [DSTEP_W-1:0] DIV_STEPS_LEAK  = 7'd64;
   localparam logic [DSTEP_W-1:0] DIV_STEPS_IDEAL = 7'd32;

   // Saturation value of the bucket.
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

endpackage

>>> rtl/core/olb_req_if.sv
// Request channel of the leaky-bucket overshoot meter.
// Carries valid, ready and the request fields; depends on olb_pkg.
interface olb_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      operation;
   logic [olb_pkg::TIME_W-1:0]      time_ms;
   logic [olb_pkg::BYTES_W-1:0]     frame_bytes;
   logic [olb_pkg::RATE_W-1:0]      new_bitrate_bps;
   logic [olb_pkg::FPS_W-1:0]       new_frame_rate;

   modport source (output valid, operation, time_ms, frame_bytes, new_bitrate_bps,
                   new_frame_rate, input ready);
   modport sink (input valid, operation, time_ms, frame_bytes, new_bitrate_bps,
                 new_frame_rate, output ready);
endinterface

>>> rtl/core/olb_rsp_if.sv
// Response channel of the leaky-bucket overshoot meter.
// Carries valid, ready and the result fields; depends on olb_pkg.
interface olb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [olb_pkg::LEVEL_W-1:0]     excess_bits;
   logic [olb_pkg::LEVEL_W-1:0]     bucket_level;

   modport source (output valid, excess_bits, bucket_level, input ready);
   modport sink (input valid, excess_bits, bucket_level, output ready);
endinterface

>>> rtl/core/olb_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Produces a 64-bit product of two 32-bit operands; depends on olb_pkg.
module olb_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [olb_pkg::RATE_W-1:0]   mcand,
   input  logic [olb_pkg::TIME_W-1:0]   mplier,
   output logic                         done,
   output logic [olb_pkg::PROD_W-1:0]   product
);
   import olb_pkg::*;

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [RATE_W-1:0]  mcand_ff, mcand_in;
   logic [MSTEP_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [RATE_W:0]    sum;

   // One step: add the multiplicand into the high half when the low bit is set,
   // then shift the whole product register right by one.
   always_comb begin
      sum      = {1'b0, prod_ff[PROD_W-1:RATE_W]} +
                 (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         prod_in  = {{RATE_W{1'b0}}, mplier};
         mcand_in = mcand;
         cnt_in   = MUL_STEPS;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[RATE_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == MSTEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

>>> rtl/core/olb_div.sv
// Restoring divider, one quotient bit per cycle, for narrow divisors.
// Divides a 64-bit dividend by a 10-bit divisor; depends on olb_pkg.
module olb_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [olb_pkg::PROD_W-1:0]     dividend,
   input  logic [olb_pkg::DIVISOR_W-1:0]  divisor,
   input  logic [olb_pkg::DSTEP_W-1:0]    steps,
   output logic                           done,
   output logic [olb_pkg::PROD_W-1:0]     quotient
);
   import olb_pkg::*;

   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DSTEP_W-1:0]   cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   // One step: bring down the next dividend bit and subtract when it fits.
   // Dividend bits leave at the top while quotient bits enter at the bottom.
   always_comb begin
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DSTEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/encoder_overshoot_leaky_bucket.sv
// Leaky-bucket overshoot meter for encoded video frames. Each request is a
// frame, a target-rate change or a reset, and each gives exactly one response
// with the frame's overshoot and the bucket level afterwards. Requests are
// handled one at a time. The leak term target_rate * elapsed / 1000 is built
// by a bit-serial multiplier (32 steps) followed by a bit-serial divider
// (64 steps); a frame or rate change after the first timestamp passes through
// the multiply, leak-divide, drain and finish states before its response is
// registered. A rate change with a nonzero frame rate also runs the divider
// (32 steps) on the ideal frame size, which is computed once there and kept.
// The first timed request and a rate restart from zero bitrate skip the leak
// and go to drain; a reset and the unused code 3 go straight to finish. The
// sequencer returns to idle as the response is registered, so the next request
// is taken while the previous response still waits; a response that cannot be
// registered because the previous one is still held stalls the sequencer.
// Depends on olb_pkg, olb_req_if, olb_rsp_if, olb_mul and olb_div.
module encoder_overshoot_leaky_bucket (
   input  logic      clock,
   input  logic      reset,
   olb_req_if.sink   req_ch,
   olb_rsp_if.source rsp_ch
);
   import olb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_MUL       = 6'b000010,
      ST_DIV_LEAK  = 6'b000100,
      ST_DRAIN     = 6'b001000,
      ST_DIV_IDEAL = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [RATE_W-1:0]    new_rate_ff, new_rate_in;
   logic [FPS_W-1:0]     new_fps_ff, new_fps_in;
   logic                 skip_ff, skip_in;
   logic                 restart_ff, restart_in;
   logic [LEVEL_W-1:0]   bucket_ff, bucket_in;
   logic [TIME_W-1:0]    last_time_ff, last_time_in;
   logic                 time_valid_ff, time_valid_in;
   logic [RATE_W-1:0]    target_rate_ff, target_rate_in;
   logic [RATE_W-1:0]    ideal_ff, ideal_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   over_out_ff, over_out_in;
   logic [LEVEL_W-1:0]   level_out_ff, level_out_in;

   logic                 req_fire;
   op_type               req_op;
   logic                 restart_now;
   logic                 leak_req;
   logic                 rsp_free;
   logic                 mul_start, mul_done;
   logic [PROD_W-1:0]    mul_product;
   logic [TIME_W-1:0]    elapsed;
   logic                 div_start, div_done;
   logic [PROD_W-1:0]    div_dividend, div_quot;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [DSTEP_W-1:0]   div_steps;
   logic [LEVEL_W-1:0]   drained;
   logic [LEVEL_W-1:0]   frame_bits;
   logic [RATE_W-1:0]    gap;
   logic                 frame_ge;
   logic                 over_ideal;
   logic [LEVEL_W-1:0]   over;
   logic [LEVEL_W-1:0]   frame_level;

   // Request handshake and the decision whether a leak has to be computed.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == ST_IDLE);
   assign req_op       = op_type'(req_ch.operation);
   assign restart_now  = (req_op == OP_SET_RATE) && (target_rate_ff == '0) &&
                         (req_ch.new_bitrate_bps != '0);
   assign leak_req     = time_valid_ff && !restart_now &&
                         ((req_op == OP_FRAME) || (req_op == OP_SET_RATE));
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Serial multiply of target rate by the wrapped elapsed time.
   assign elapsed   = req_ch.time_ms - last_time_ff;
   assign mul_start = req_fire && leak_req;

   olb_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (target_rate_ff),
      .mplier  (elapsed),
      .done    (mul_done),
      .product (mul_product)
   );

   // The divider is shared between the leak (product / 1000) and the ideal
   // frame size (new rate / new frame rate, dividend placed in the top half).
   always_comb begin
      div_start    = 1'b0;
      div_dividend = mul_product;
      div_divisor  = MS_PER_S;
      div_steps    = DIV_STEPS_LEAK;
      if (state_ff == ST_MUL) begin
         div_start = mul_done;
      end else if (state_ff == ST_DRAIN) begin
         div_start    = (op_ff == OP_SET_RATE) && (new_fps_ff != '0);
         div_dividend = {new_rate_ff, {(PROD_W-RATE_W){1'b0}}};
         div_divisor  = {{(DIVISOR_W-FPS_W){1'b0}}, new_fps_ff};
         div_steps    = DIV_STEPS_IDEAL;
      end
   end

   olb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Bucket after draining, never below zero.
   always_comb begin
      if (restart_ff) begin
         drained = '0;
      end else if (skip_ff) begin
         drained = bucket_ff;
      end else if (div_quot > {{(PROD_W-LEVEL_W){1'b0}}, bucket_ff}) begin
         drained = '0;
      end else begin
         drained = bucket_ff - div_quot[LEVEL_W-1:0];
      end
   end

   // Frame update. A frame at least as large as the ideal size takes the whole
   // bucket as overshoot and leaves only its own bits. A smaller frame leaves a
   // gap below the ideal size: a bucket above that gap is cut back so that the
   // level lands on the ideal size, otherwise the frame's bits are added. The
   // level never exceeds the larger of the frame and the ideal size.
   always_comb begin
      frame_bits = {{(LEVEL_W-BYTES_W-3){1'b0}}, bytes_ff, 3'b000};
      frame_ge   = (frame_bits >= {{(LEVEL_W-RATE_W){1'b0}}, ideal_ff});
      gap        = ideal_ff - frame_bits[RATE_W-1:0];
      over_ideal = (bucket_ff > {{(LEVEL_W-RATE_W){1'b0}}, gap});
      if (frame_ge) begin
         over        = bucket_ff;
         frame_level = frame_bits;
      end else if (over_ideal) begin
         over        = bucket_ff - {{(LEVEL_W-RATE_W){1'b0}}, gap};
         frame_level = {{(LEVEL_W-RATE_W){1'b0}}, ideal_ff};
      end else begin
         over        = '0;
         frame_level = bucket_ff + frame_bits;
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      now_in         = now_ff;
      bytes_in       = bytes_ff;
      new_rate_in    = new_rate_ff;
      new_fps_in     = new_fps_ff;
      skip_in        = skip_ff;
      restart_in     = restart_ff;
      bucket_in      = bucket_ff;
      last_time_in   = last_time_ff;
      time_valid_in  = time_valid_ff;
      target_rate_in = target_rate_ff;
      ideal_in       = ideal_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      over_out_in    = over_out_ff;
      level_out_in   = level_out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_op;
               now_in      = req_ch.time_ms;
               bytes_in    = req_ch.frame_bytes;
               new_rate_in = req_ch.new_bitrate_bps;
               new_fps_in  = req_ch.new_frame_rate;
               skip_in     = !leak_req;
               restart_in  = restart_now;
               if ((req_op == OP_FRAME) || (req_op == OP_SET_RATE)) begin
                  state_in = leak_req ? ST_MUL : ST_DRAIN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV_LEAK;
            end
         end
         ST_DIV_LEAK: begin
            if (div_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            bucket_in     = drained;
            last_time_in  = now_ff;
            time_valid_in = 1'b1;
            state_in      = ST_FINISH;
            if (op_ff == OP_SET_RATE) begin
               target_rate_in = new_rate_ff;
               if (new_fps_ff == '0) begin
                  ideal_in = '0;
               end else begin
                  state_in = ST_DIV_IDEAL;
               end
            end
         end
         ST_DIV_IDEAL: begin
            if (div_done) begin
               ideal_in = div_quot[RATE_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               over_out_in  = '0;
               level_out_in = bucket_ff;
               state_in     = ST_IDLE;
               case (op_ff)
                  OP_FRAME: begin
                     bucket_in    = frame_level;
                     over_out_in  = over;
                     level_out_in = frame_level;
                  end
                  OP_RESET: begin
                     bucket_in      = '0;
                     last_time_in   = '0;
                     time_valid_in  = 1'b0;
                     target_rate_in = '0;
                     ideal_in       = '0;
                     level_out_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      now_ff       <= now_in;
      bytes_ff     <= bytes_in;
      new_rate_ff  <= new_rate_in;
      new_fps_ff   <= new_fps_in;
      skip_ff      <= skip_in;
      restart_ff   <= restart_in;
      over_out_ff  <= over_out_in;
      level_out_ff <= level_out_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         bucket_ff      <= '0;
         last_time_ff   <= '0;
         time_valid_ff  <= 1'b0;
         target_rate_ff <= '0;
         ideal_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bucket_ff      <= bucket_in;
         last_time_ff   <= last_time_in;
         time_valid_ff  <= time_valid_in;
         target_rate_ff <= target_rate_in;
         ideal_ff       <= ideal_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response register.
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.excess_bits  = over_out_ff;
   assign rsp_ch.bucket_level = level_out_ff;

endmodule
